// ----- design/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/npcs_pkg.sv -----
// package: palette rom, shade scaling functions and shared types
`default_nettype none
package npcs_pkg;

    localparam int ROM_ROWS = 34;
    localparam int PALETTE_SIZE_DEF = 34;
    localparam int IDX_W = 6;
    localparam int Q_W = 16;
    localparam int DIST_W = 35;

    localparam logic [1:0] LVL_MID = 2'd0;
    localparam logic [1:0] LVL_HIGH = 2'd1;
    localparam logic [1:0] LVL_LOW = 2'd3;

    localparam int NUM_MID = 220;
    localparam int NUM_LOW = 180;
    localparam int NUM_HIGH = 255;

    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] code;
        logic [3:0] variant;
    } pal_row_t;

    typedef struct packed {
        dist_t           dsq;
        logic [IDX_W-1:0] idx;
        logic [1:0]       lvl;
    } cand_t;

    localparam pal_row_t PAL_ROM [ROM_ROWS] = '{
        '{8'd127, 8'd178, 8'd56,  8'h02, 4'd0},
        '{8'd247, 8'd233, 8'd163, 8'h2c, 4'd1},
        '{8'd255, 8'd0,   8'd0,   8'h98, 4'd0},
        '{8'd160, 8'd160, 8'd255, 8'hae, 4'd0},
        '{8'd167, 8'd167, 8'd167, 8'h94, 4'd0},
        '{8'd0,   8'd124, 8'd0,   8'h12, 4'd0},
        '{8'd255, 8'd255, 8'd255, 8'hab, 4'd0},
        '{8'd164, 8'd168, 8'd184, 8'h52, 4'd0},
        '{8'd183, 8'd106, 8'd47,  8'h7e, 4'd3},
        '{8'd112, 8'd112, 8'd112, 8'h2c, 4'd3},
        '{8'd64,  8'd64,  8'd255, 8'h09, 4'd0},
        '{8'd104, 8'd83,  8'd50,  8'h7e, 4'd0},
        '{8'd255, 8'd252, 8'd245, 8'h01, 4'd3},
        '{8'd216, 8'd127, 8'd51,  8'hab, 4'd1},
        '{8'd178, 8'd76,  8'd216, 8'hab, 4'd2},
        '{8'd102, 8'd153, 8'd216, 8'hab, 4'd3},
        '{8'd229, 8'd229, 8'd51,  8'hab, 4'd4},
        '{8'd127, 8'd204, 8'd25,  8'hab, 4'd5},
        '{8'd242, 8'd127, 8'd165, 8'hab, 4'd6},
        '{8'd76,  8'd76,  8'd76,  8'hab, 4'd7},
        '{8'd153, 8'd153, 8'd153, 8'hab, 4'd8},
        '{8'd76,  8'd127, 8'd153, 8'hab, 4'd9},
        '{8'd127, 8'd63,  8'd178, 8'hab, 4'd10},
        '{8'd51,  8'd76,  8'd178, 8'hab, 4'd11},
        '{8'd102, 8'd76,  8'd51,  8'hab, 4'd12},
        '{8'd102, 8'd127, 8'd51,  8'hab, 4'd13},
        '{8'd153, 8'd51,  8'd51,  8'hab, 4'd14},
        '{8'd25,  8'd25,  8'd25,  8'hab, 4'd15},
        '{8'd250, 8'd238, 8'd77,  8'h93, 4'd0},
        '{8'd92,  8'd219, 8'd213, 8'ha8, 4'd1},
        '{8'd74,  8'd128, 8'd255, 8'h16, 4'd0},
        '{8'd0,   8'd217, 8'd58,  8'h85, 4'd0},
        '{8'd21,  8'd20,  8'd31,  8'h7e, 4'd1},
        '{8'd112, 8'd2,   8'd0,   8'h57, 4'd0}
    };

    // rounded q8.8 shade of one component, evaluated on constants only
    function automatic logic [Q_W-1:0] scale_q(input int c, input int num);
        int v;
        v = (c * num * 256 + 127) / 255;
        return v[Q_W-1:0];
    endfunction

    // squared distance between a scaled color and a pixel, q16.16
    function automatic dist_t comp_sq(input logic [Q_W-1:0] s, input logic [7:0] x);
        logic [Q_W-1:0] pix;
        logic [Q_W-1:0] d;
        logic [2*Q_W-1:0] p;
        pix = {x, 8'd0};
        d = (s >= pix) ? (s - pix) : (pix - s);
        p = d * d;
        return DIST_W'(p);
    endfunction

endpackage
`default_nettype wire

// ----- design/npcs_cand.sv -----
// one candidate lane: squared distance of a pixel to one shaded palette color
`default_nettype none
module npcs_cand #(
    parameter int ROW = 0,
    parameter int NUM = npcs_pkg::NUM_MID
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [7:0]           red,
    input  wire logic [7:0]           green,
    input  wire logic [7:0]           blue,
    output npcs_pkg::dist_t           dsq
);
    localparam logic [npcs_pkg::Q_W-1:0] SR =
        npcs_pkg::scale_q(int'(npcs_pkg::PAL_ROM[ROW].red), NUM);
    localparam logic [npcs_pkg::Q_W-1:0] SG =
        npcs_pkg::scale_q(int'(npcs_pkg::PAL_ROM[ROW].green), NUM);
    localparam logic [npcs_pkg::Q_W-1:0] SB =
        npcs_pkg::scale_q(int'(npcs_pkg::PAL_ROM[ROW].blue), NUM);

    npcs_pkg::dist_t sq_r_reg, sq_g_reg, sq_b_reg;

    // squares are registered, the sum is left to the next stage
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_r_reg <= npcs_pkg::comp_sq(SR, red);
            sq_g_reg <= npcs_pkg::comp_sq(SG, green);
            sq_b_reg <= npcs_pkg::comp_sq(SB, blue);
        end
    end

    assign dsq = sq_r_reg + sq_g_reg + sq_b_reg;
endmodule
`default_nettype wire

// ----- design/nearest_palette_color_shaded.sv -----
// top level: pipelined nearest shaded palette color search
//  channel | dir | tdata bits                      | tuser
//  s_axis  | in  | [7:0] red [15:8] green [23:16] blue | -
//  m_axis  | out | [5:0] palette_index [7:6] shade_level [15:8] block_code
//          |     | [19:16] block_variant, zero to 24 bits | -
// one pixel per cycle; 3 + ceil(log2(3*rows)) register stages: the square
// stage, the distance sum stage, the registered min tree and the output register
// the whole pipe advances together and holds when the output beat is not taken
// synchronous active-low reset clears valid bits; flat_mode resets to 1
`default_nettype none
`include "assert_macros.svh"
module nearest_palette_color_shaded #(
    parameter int PALETTE_SIZE = npcs_pkg::PALETTE_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_wdata,     // flat_mode
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // red, green, blue
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata   // palette_index, shade_level, code, variant
);
    localparam int ROWS = (PALETTE_SIZE < npcs_pkg::ROM_ROWS) ?
        PALETTE_SIZE : npcs_pkg::ROM_ROWS;
    localparam int NC = 3 * ROWS;
    localparam int LV = (NC > 1) ? $clog2(NC) : 1;
    localparam int NP = 1 << LV;
    localparam int DEPTH = LV + 3;

    localparam npcs_pkg::dist_t BIG = '1;

    logic adv;
    logic [DEPTH-1:0] vld_reg;
    logic flat_reg;
    logic [DEPTH-1:0] flat_pipe_reg;

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flat_reg <= 1'b1;
        end else if (cfg_we) begin
            flat_reg <= cfg_wdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            flat_pipe_reg <= {flat_pipe_reg[DEPTH-2:0], flat_reg};
        end
    end

    // candidates in search order: entry, then mid, low, high
    npcs_pkg::dist_t dist_w [NC];

    for (genvar i = 0; i < ROWS; i++) begin : g_row
        npcs_cand #(.ROW(i), .NUM(npcs_pkg::NUM_MID)) u_mid (
            .aclk(aclk), .en(adv), .red(s_axis_tdata[7:0]),
            .green(s_axis_tdata[15:8]), .blue(s_axis_tdata[23:16]),
            .dsq(dist_w[3*i]));
        npcs_cand #(.ROW(i), .NUM(npcs_pkg::NUM_LOW)) u_low (
            .aclk(aclk), .en(adv), .red(s_axis_tdata[7:0]),
            .green(s_axis_tdata[15:8]), .blue(s_axis_tdata[23:16]),
            .dsq(dist_w[3*i+1]));
        npcs_cand #(.ROW(i), .NUM(npcs_pkg::NUM_HIGH)) u_high (
            .aclk(aclk), .en(adv), .red(s_axis_tdata[7:0]),
            .green(s_axis_tdata[15:8]), .blue(s_axis_tdata[23:16]),
            .dsq(dist_w[3*i+2]));
    end

    // sum stage: flat mode masks shaded candidates
    npcs_pkg::cand_t leaf_reg [NP];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NP; k++) begin
                if (k < NC) begin
                    leaf_reg[k].dsq <= (flat_pipe_reg[0] && (k % 3 != 0)) ? BIG : dist_w[k];
                    leaf_reg[k].idx <= npcs_pkg::IDX_W'(k / 3);
                    leaf_reg[k].lvl <= (k % 3 == 0) ? npcs_pkg::LVL_MID :
                                       (k % 3 == 1) ? npcs_pkg::LVL_LOW : npcs_pkg::LVL_HIGH;
                end else begin
                    leaf_reg[k].dsq <= BIG;
                    leaf_reg[k].idx <= '0;
                    leaf_reg[k].lvl <= npcs_pkg::LVL_MID;
                end
            end
        end
    end

    // registered min tree, left wins ties to keep first-found order
    npcs_pkg::cand_t tree_reg [LV][NP];

    for (genvar l = 0; l < LV; l++) begin : g_lvl
        localparam int N = NP >> (l + 1);
        for (genvar j = 0; j < N; j++) begin : g_node
            npcs_pkg::cand_t a, b;
            if (l == 0) begin : g_leaf
                assign a = leaf_reg[2*j];
                assign b = leaf_reg[2*j+1];
            end else begin : g_inner
                assign a = tree_reg[l-1][2*j];
                assign b = tree_reg[l-1][2*j+1];
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    tree_reg[l][j] <= (b.dsq < a.dsq) ? b : a;
                end
            end
        end
        for (genvar j = N; j < NP; j++) begin : g_pad
            always_ff @(posedge aclk) begin
                tree_reg[l][j] <= '0;
            end
        end
    end

    npcs_pkg::cand_t win;
    npcs_pkg::pal_row_t win_row;
    logic [23:0] out_reg;

    assign win = tree_reg[LV-1][0];

    always_comb begin
        win_row = npcs_pkg::PAL_ROM[0];
        for (int k = 0; k < ROWS; k++) begin
            if (win.idx == npcs_pkg::IDX_W'(k)) begin
                win_row = npcs_pkg::PAL_ROM[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= {4'd0, win_row.variant, win_row.code, win.lvl, win.idx};
        end
    end

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata = out_reg;

    `ASSERT_ALWAYS(a_idx_range, aclk, aresetn,
        !m_axis_tvalid || (32'(m_axis_tdata[5:0]) < ROWS), "index beyond palette")
    `ASSERT_ALWAYS(a_lvl_code, aclk, aresetn,
        !m_axis_tvalid || (m_axis_tdata[7:6] != 2'd2), "bad shade code")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")
    `ASSERT_ALWAYS(a_flat_mid, aclk, aresetn,
        !(m_axis_tvalid && flat_pipe_reg[DEPTH-1]) || (m_axis_tdata[7:6] == 2'd0),
        "shaded result in flat mode")
endmodule
`default_nettype wire

// ----- bench/tb_nearest_palette_color_shaded.sv -----
// testbench: random and directed pixel stream against a palette search predictor
`default_nettype none
module tb_nearest_palette_color_shaded;

    typedef struct packed {
        logic [3:0] variant;
        logic [7:0] code;
        logic [1:0] lvl;
        logic [5:0] idx;
    } match_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_wdata = 1'b1;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    nearest_palette_color_shaded DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    logic [23:0] pixel_q[$];
    match_t      match_q[$];
    bit          flat_now = 1'b1;
    bit          quiet_tail = 1'b0;
    bit          hold_off = 1'b0;
    int          mismatches = 0;
    int          matched = 0;
    int          sent = 0;
    longint      cycles = 0;

    function automatic longint shade_dist(int r, int num, logic [23:0] px);
        longint sum;
        int c, s, x, d;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            c = (k == 0) ? npcs_pkg::PAL_ROM[r].red :
                (k == 1) ? npcs_pkg::PAL_ROM[r].green : npcs_pkg::PAL_ROM[r].blue;
            x = px[8*k +: 8];
            s = (c * num * 256 + 127) / 255;
            d = (s >= x * 256) ? s - x * 256 : x * 256 - s;
            sum += longint'(d) * longint'(d);
        end
        return sum;
    endfunction

    function automatic match_t nearest_shade(logic [23:0] px, bit flat);
        longint best, d;
        match_t m;
        best = longint'(1000000) << 16;
        m = '0;
        for (int r = 0; r < npcs_pkg::ROM_ROWS; r++) begin
            d = shade_dist(r, npcs_pkg::NUM_MID, px);
            if (d < best) begin best = d; m.idx = 6'(r); m.lvl = npcs_pkg::LVL_MID; end
            if (!flat) begin
                d = shade_dist(r, npcs_pkg::NUM_LOW, px);
                if (d < best) begin best = d; m.idx = 6'(r); m.lvl = npcs_pkg::LVL_LOW; end
                d = shade_dist(r, npcs_pkg::NUM_HIGH, px);
                if (d < best) begin best = d; m.idx = 6'(r); m.lvl = npcs_pkg::LVL_HIGH; end
            end
        end
        m.code = npcs_pkg::PAL_ROM[m.idx].code;
        m.variant = npcs_pkg::PAL_ROM[m.idx].variant;
        return m;
    endfunction

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                match_q.push_back(nearest_shade(s_axis_tdata, flat_now));
                sent <= sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    if (!quiet_tail && $urandom_range(9) == 0) begin
                        s_gap <= $urandom_range(14);
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        s_axis_tdata <= pixel_q.pop_front();
                        s_axis_tvalid <= 1'b1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int m_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (match_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected beat %h", m_axis_tdata);
                end else begin
                    match_t e;
                    e = match_q.pop_front();
                    if (m_axis_tdata !== {4'd0, e}) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch exp idx %0d lvl %0d code %h var %0d, got %h",
                                     e.idx, e.lvl, e.code, e.variant, m_axis_tdata);
                    end else begin
                        matched <= matched + 1;
                    end
                end
            end
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(9) == 0) begin
                m_gap <= $urandom_range(14);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // long receiver stall while the sender keeps offering
    initial begin
        int n;
        wait (sent > 300);
        @(posedge aclk);
        hold_off <= 1'b1;
        for (n = 0; n < 60; n++) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        if (cycles > 200000) begin
            $display("tb_nearest_palette_color_shaded NOT OK");
            $finish;
        end
    end

    task automatic drain();
        wait (pixel_q.size() == 0);
        @(posedge aclk);
        while (s_axis_tvalid || match_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_flat(bit v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        flat_now = v;
        @(posedge aclk);
    endtask

    function automatic logic [23:0] near_entry();
        int r, c;
        logic [23:0] px;
        r = $urandom_range(npcs_pkg::ROM_ROWS - 1);
        for (int k = 0; k < 3; k++) begin
            c = (k == 0) ? npcs_pkg::PAL_ROM[r].red :
                (k == 1) ? npcs_pkg::PAL_ROM[r].green : npcs_pkg::PAL_ROM[r].blue;
            c = c * (($urandom_range(2) == 0) ? 180 : ($urandom_range(1) ? 220 : 255)) / 255;
            c = c + int'($urandom_range(8)) - 4;
            px[8*k +: 8] = 8'((c < 0) ? 0 : (c > 255) ? 255 : c);
        end
        return px;
    endfunction

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++)
            pixel_q.push_back($urandom_range(1) ? 24'($urandom) : near_entry());
    endtask

    initial begin
        logic [23:0] corners[$];
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: extremes and exact palette colors, reset flat mode
        corners = '{24'h000000, 24'hffffff, 24'h0000ff, 24'h00ff00, 24'hff0000,
                    24'h010101, 24'hfefefe, 24'h38b27f, 24'h000270, 24'hdbdbdb};
        foreach (corners[i]) pixel_q.push_back(corners[i]);
        drain();
        set_flat(1'b0);
        foreach (corners[i]) pixel_q.push_back(corners[i]);
        pixel_q.push_back(24'h8c8c8c);
        pixel_q.push_back(24'h7d7d7d);
        random_burst(500);
        drain();
        // sender pauses until all results arrived
        set_flat(1'b1);
        random_burst(500);
        drain();
        set_flat(1'b0);
        quiet_tail = 1'b1;
        random_burst(530);
        drain();
        $display("covered %0d pixels in flat and shaded modes, %0d results matched",
                 sent, matched);
        if (mismatches == 0 && match_q.size() == 0)
            $display("tb_nearest_palette_color_shaded OK");
        else
            $display("tb_nearest_palette_color_shaded NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
